>>> rtl/cng_pkg.sv
package cng_pkg;

    // field widths
    localparam int CP_W   = 21;
    localparam int OFF_W  = 32;
    localparam int LEN_W  = 3;
    localparam int CFG_W  = 3;

    // gram characters carried by one result
    localparam int NUM_CHARS = 4;

    // default window depth
    localparam int MAX_GRAM_DEF = 4;

    // job queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // configuration port
    localparam int APB_DW = 32;
    localparam int APB_AW = 3;
    localparam logic [APB_AW-3:0] REG_MIN_GRAM = 1'b0;
    localparam logic [APB_AW-3:0] REG_MAX_GRAM = 1'b1;

    localparam logic [CFG_W-1:0] MIN_GRAM_RST = 3'd1;
    localparam logic [CFG_W-1:0] MAX_GRAM_RST = 3'd2;

    typedef struct packed {
        logic [CFG_W-1:0] min_gram;
        logic [CFG_W-1:0] max_gram;
    } cfg_t;

    // one unit of work for the back end
    typedef struct packed {
        logic             is_end;
        logic             has_grams;
        logic [LEN_W-1:0] min_len;
        logic [LEN_W-1:0] k_start;
        logic [OFF_W-1:0] count;
    } job_t;

endpackage

>>> rtl/cng_if.sv
interface cng_in_if;
    logic                      valid;
    logic                      ready;
    logic [cng_pkg::CP_W-1:0]  code_point;
    logic                      end_of_text;

    modport source (output valid, output code_point, output end_of_text, input ready);
    modport sink   (input valid, input code_point, input end_of_text, output ready);
endinterface

interface cng_out_if;
    logic                       valid;
    logic                       ready;
    logic [cng_pkg::OFF_W-1:0]  start_offset;
    logic [cng_pkg::LEN_W-1:0]  gram_length;
    logic [cng_pkg::CP_W-1:0]   char_first;
    logic [cng_pkg::CP_W-1:0]   char_second;
    logic [cng_pkg::CP_W-1:0]   char_third;
    logic [cng_pkg::CP_W-1:0]   char_fourth;
    logic                       is_end;
    logic                       last;

    modport source (output valid, output start_offset, output gram_length,
                    output char_first, output char_second, output char_third,
                    output char_fourth, output is_end, output last, input ready);
    modport sink   (input valid, input start_offset, input gram_length,
                    input char_first, input char_second, input char_third,
                    input char_fourth, input is_end, input last, output ready);
endinterface

>>> rtl/cng_front.sv
module cng_front #(
    parameter int MAX_GRAM = cng_pkg::MAX_GRAM_DEF
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    cng_in_if.sink                                   in_ch,
    input  cng_pkg::cfg_t                            cfg,
    input  logic                                     q_not_full,
    output logic                                     push,
    output cng_pkg::job_t                            push_job,
    output logic [MAX_GRAM-1:0][cng_pkg::CP_W-1:0]   push_win
);

    localparam logic [cng_pkg::LEN_W-1:0] MAX_LEN =
        cng_pkg::LEN_W'((MAX_GRAM > 7) ? 7 : MAX_GRAM);

    logic [MAX_GRAM-1:0][cng_pkg::CP_W-1:0] win_reg, win_next;
    logic [cng_pkg::OFF_W-1:0]              count_reg, count_next;
    logic [cng_pkg::OFF_W-1:0]              count_inc;
    logic [cng_pkg::LEN_W-1:0]              mn_eff, mx_eff, mx_less, kmax;
    logic                                   grams, fire;

    assign in_ch.ready = q_not_full;
    assign fire        = in_ch.valid && in_ch.ready;

    always_comb
    begin
        mn_eff    = (cfg.min_gram == '0) ? cng_pkg::LEN_W'(1) : cfg.min_gram;
        mx_eff    = (cfg.max_gram > MAX_LEN) ? MAX_LEN : cfg.max_gram;
        mx_less   = mx_eff - cng_pkg::LEN_W'(1);
        grams     = (mn_eff <= mx_eff);
        count_inc = (count_reg == '1) ? count_reg : count_reg + cng_pkg::OFF_W'(1);
        kmax      = (count_reg >= {{(cng_pkg::OFF_W-cng_pkg::LEN_W){1'b0}}, mx_less})
                    ? mx_less : count_reg[cng_pkg::LEN_W-1:0];

        win_next   = win_reg;
        count_next = count_reg;
        push       = 1'b0;
        push_job   = '0;
        push_win   = win_reg;

        if (fire)
        begin
            if (!in_ch.end_of_text)
            begin
                // shift in the new character, newest at entry 0
                for (int i = MAX_GRAM - 1; i > 0; i--)
                begin
                    win_next[i] = win_reg[i-1];
                end
                win_next[0] = in_ch.code_point;
                count_next  = count_inc;
                push_win    = win_next;
                push = grams &&
                       (count_inc >= {{(cng_pkg::OFF_W-cng_pkg::LEN_W){1'b0}}, mx_eff});
                push_job.is_end    = 1'b0;
                push_job.has_grams = 1'b1;
                push_job.min_len   = mn_eff;
                push_job.k_start   = mx_eff;
                push_job.count     = count_inc;
            end
            else
            begin
                push               = 1'b1;
                push_job.is_end    = 1'b1;
                push_job.has_grams = grams && (kmax >= mn_eff);
                push_job.min_len   = mn_eff;
                push_job.k_start   = kmax;
                push_job.count     = count_reg;
                win_next           = '0;
                count_next         = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg   <= '0;
            count_reg <= '0;
        end
        else
        begin
            win_reg   <= win_next;
            count_reg <= count_next;
        end
    end

endmodule

>>> rtl/cng_queue.sv
module cng_queue #(
    parameter int MAX_GRAM = cng_pkg::MAX_GRAM_DEF
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     push,
    input  cng_pkg::job_t                            push_job,
    input  logic [MAX_GRAM-1:0][cng_pkg::CP_W-1:0]   push_win,
    output logic                                     not_full,
    input  logic                                     pop,
    output cng_pkg::job_t                            head_job,
    output logic [MAX_GRAM-1:0][cng_pkg::CP_W-1:0]   head_win,
    output logic                                     not_empty
);

    localparam int PW = $clog2(cng_pkg::QUEUE_DEPTH);
    localparam int CW = $clog2(cng_pkg::QUEUE_DEPTH + 1);

    cng_pkg::job_t                          job_mem [cng_pkg::QUEUE_DEPTH];
    logic [MAX_GRAM-1:0][cng_pkg::CP_W-1:0] win_mem [cng_pkg::QUEUE_DEPTH];

    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] fill_reg;
    logic          do_push, do_pop;

    assign not_full  = (fill_reg != CW'(cng_pkg::QUEUE_DEPTH));
    assign not_empty = (fill_reg != '0);
    assign do_push   = push && not_full;
    assign do_pop    = pop && not_empty;
    assign head_job  = job_mem[rd_ptr_reg];
    assign head_win  = win_mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            job_mem[wr_ptr_reg] <= push_job;
            win_mem[wr_ptr_reg] <= push_win;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(cng_pkg::QUEUE_DEPTH - 1))
                              ? '0 : wr_ptr_reg + PW'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(cng_pkg::QUEUE_DEPTH - 1))
                              ? '0 : rd_ptr_reg + PW'(1);
            end
            if (do_push && !do_pop)
            begin
                fill_reg <= fill_reg + CW'(1);
            end
            else if (do_pop && !do_push)
            begin
                fill_reg <= fill_reg - CW'(1);
            end
        end
    end

endmodule

>>> rtl/cng_back.sv
module cng_back #(
    parameter int MAX_GRAM = cng_pkg::MAX_GRAM_DEF
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     q_not_empty,
    input  cng_pkg::job_t                            head_job,
    input  logic [MAX_GRAM-1:0][cng_pkg::CP_W-1:0]   head_win,
    output logic                                     pop,
    cng_out_if.source                                out_ch
);

    cng_pkg::job_t                          job_reg;
    logic [MAX_GRAM-1:0][cng_pkg::CP_W-1:0] win_reg;
    logic                                   active_reg, final_reg;
    logic [cng_pkg::LEN_W-1:0]              k_reg, s_reg;

    logic                                   out_valid_reg;
    logic [cng_pkg::OFF_W-1:0]              off_reg;
    logic [cng_pkg::LEN_W-1:0]              len_reg;
    logic [cng_pkg::NUM_CHARS-1:0][cng_pkg::CP_W-1:0] chars_reg;
    logic                                   is_end_reg, last_reg;

    logic                                   out_free, emit, done;
    logic [cng_pkg::LEN_W-1:0]              top;
    logic [cng_pkg::OFF_W-1:0]              cur_off;
    logic [cng_pkg::LEN_W-1:0]              cur_len;
    logic [cng_pkg::NUM_CHARS-1:0][cng_pkg::CP_W-1:0] cur_chars;
    logic                                   cur_last;

    assign out_free = !out_valid_reg || out_ch.ready;
    assign emit     = active_reg && out_free;
    assign done     = emit && cur_last;
    assign pop      = q_not_empty && (!active_reg || done);

    // current result from the job and the two gram counters
    always_comb
    begin
        top       = k_reg - cng_pkg::LEN_W'(1);
        cur_chars = '0;
        if (final_reg)
        begin
            cur_off  = job_reg.count;
            cur_len  = '0;
            cur_last = 1'b1;
        end
        else
        begin
            cur_off  = job_reg.count -
                       {{(cng_pkg::OFF_W-cng_pkg::LEN_W){1'b0}}, k_reg};
            cur_len  = s_reg;
            cur_last = !job_reg.is_end && (s_reg == k_reg);
            for (int j = 0; j < cng_pkg::NUM_CHARS; j++)
            begin
                if (cng_pkg::LEN_W'(j) < s_reg)
                begin
                    for (int e = 0; e < MAX_GRAM; e++)
                    begin
                        if ({1'b0, top} == (cng_pkg::LEN_W + 1)'(e + j))
                        begin
                            cur_chars[j] = win_reg[e];
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            job_reg <= head_job;
            win_reg <= head_win;
            k_reg   <= head_job.k_start;
            s_reg   <= head_job.min_len;
        end
        else if (emit && !final_reg && !done)
        begin
            if (s_reg == k_reg)
            begin
                // next shorter tail position
                k_reg <= k_reg - cng_pkg::LEN_W'(1);
                s_reg <= job_reg.min_len;
            end
            else
            begin
                s_reg <= s_reg + cng_pkg::LEN_W'(1);
            end
        end
        if (emit)
        begin
            off_reg    <= cur_off;
            len_reg    <= cur_len;
            chars_reg  <= cur_chars;
            is_end_reg <= final_reg;
            last_reg   <= cur_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            final_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                active_reg <= 1'b1;
                final_reg  <= !head_job.has_grams;
            end
            else if (done)
            begin
                active_reg <= 1'b0;
            end
            else if (emit && !final_reg && (s_reg == k_reg) &&
                     (k_reg == job_reg.min_len))
            begin
                final_reg <= 1'b1;
            end

            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.start_offset = off_reg;
    assign out_ch.gram_length  = len_reg;
    assign out_ch.char_first   = chars_reg[0];
    assign out_ch.char_second  = chars_reg[1];
    assign out_ch.char_third   = chars_reg[2];
    assign out_ch.char_fourth  = chars_reg[3];
    assign out_ch.is_end       = is_end_reg;
    assign out_ch.last         = last_reg;

`ifndef SYNTHESIS
    a_final_gives_end: assert property (@(posedge clk) disable iff (!rst_n)
        emit && final_reg |=> out_ch.valid && out_ch.is_end && out_ch.last)
        else $error("end result not produced by final step");

    a_len_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg && !final_reg |-> (s_reg <= k_reg) && (s_reg >= job_reg.min_len))
        else $error("gram length counter out of range");

    a_char_job_no_final: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg && !job_reg.is_end |-> !final_reg)
        else $error("character job entered end step");

    a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
        done && !q_not_empty |=> !active_reg)
        else $error("job still active after last result");
`endif

endmodule

>>> rtl/character_ngram_emitter_core.sv
// path: each item's job passes the queue and the job register of cng_back
// results: one per cycle out of the gram sequencer in cng_back while the output
//   register is free; the queue lets the front take new items while the back works
// a character with no complete position posts no job and gives no result
// reset: rst_n asynchronous active low, clears window, count, queue and output valid,
//   min_gram to 1 and max_gram to 2; no clearing pass
module character_ngram_emitter_core #(
    parameter int MAX_GRAM = cng_pkg::MAX_GRAM_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    cng_in_if.sink                       in_ch,
    cng_out_if.source                    out_ch,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [cng_pkg::APB_AW-1:0]   paddr,
    input  logic [cng_pkg::APB_DW-1:0]   pwdata,
    output logic [cng_pkg::APB_DW-1:0]   prdata,
    output logic                         pready
);

    // configuration registers
    logic [cng_pkg::CFG_W-1:0]     min_gram_reg;
    logic [cng_pkg::CFG_W-1:0]     max_gram_reg;
    logic [cng_pkg::APB_AW-3:0]    reg_index;
    logic                          cfg_write;
    cng_pkg::cfg_t                 cfg;

    // front to queue
    logic                                   push;
    cng_pkg::job_t                          push_job;
    logic [MAX_GRAM-1:0][cng_pkg::CP_W-1:0] push_win;
    logic                                   q_not_full;

    // queue to back
    logic                                   pop;
    cng_pkg::job_t                          head_job;
    logic [MAX_GRAM-1:0][cng_pkg::CP_W-1:0] head_win;
    logic                                   q_not_empty;

    // registers sit on word boundaries, so the index is the address above bit 1
    assign reg_index = paddr[cng_pkg::APB_AW-1:2];
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_gram_reg <= cng_pkg::MIN_GRAM_RST;
            max_gram_reg <= cng_pkg::MAX_GRAM_RST;
        end
        else if (cfg_write)
        begin
            case (reg_index)
                cng_pkg::REG_MIN_GRAM: min_gram_reg <= pwdata[cng_pkg::CFG_W-1:0];
                cng_pkg::REG_MAX_GRAM: max_gram_reg <= pwdata[cng_pkg::CFG_W-1:0];
                default:               ;
            endcase
        end
    end

    // read back
    always_comb
    begin
        case (reg_index)
            cng_pkg::REG_MIN_GRAM:
                prdata = {{(cng_pkg::APB_DW-cng_pkg::CFG_W){1'b0}}, min_gram_reg};
            cng_pkg::REG_MAX_GRAM:
                prdata = {{(cng_pkg::APB_DW-cng_pkg::CFG_W){1'b0}}, max_gram_reg};
            default:
                prdata = '0;
        endcase
    end

    assign cfg.min_gram = min_gram_reg;
    assign cfg.max_gram = max_gram_reg;

    // front: takes every transfer, keeps window and count, posts a job when
    // a position completes (with min_gram not above max_gram) or the text ends
    cng_front #(
        .MAX_GRAM (MAX_GRAM)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .cfg        (cfg),
        .q_not_full (q_not_full),
        .push       (push),
        .push_job   (push_job),
        .push_win   (push_win)
    );

    // short job queue, each job snapshots the window it needs
    cng_queue #(
        .MAX_GRAM (MAX_GRAM)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_job  (push_job),
        .push_win  (push_win),
        .not_full  (q_not_full),
        .pop       (pop),
        .head_job  (head_job),
        .head_win  (head_win),
        .not_empty (q_not_empty)
    );

    // back: walks gram lengths and tail positions, one result per cycle into
    // the output register while it is free
    cng_back #(
        .MAX_GRAM (MAX_GRAM)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .head_job    (head_job),
        .head_win    (head_win),
        .pop         (pop),
        .out_ch      (out_ch)
    );

endmodule

>>> tb/cng_gram_sb_pkg.sv
`timescale 1ns / 1ps

package cng_gram_sb_pkg;

    typedef struct packed {
        logic [cng_pkg::OFF_W-1:0] start_offset;
        logic [cng_pkg::LEN_W-1:0] gram_length;
        logic [cng_pkg::CP_W-1:0]  char_first;
        logic [cng_pkg::CP_W-1:0]  char_second;
        logic [cng_pkg::CP_W-1:0]  char_third;
        logic [cng_pkg::CP_W-1:0]  char_fourth;
        logic                      is_end;
        logic                      last;
    } gram_t;

    class gram_scoreboard;
        logic [cng_pkg::CP_W-1:0]  window [cng_pkg::MAX_GRAM_DEF];
        logic [cng_pkg::OFF_W-1:0] seen;
        logic [cng_pkg::CFG_W-1:0] min_reg;
        logic [cng_pkg::CFG_W-1:0] max_reg;
        gram_t                     pending_grams [$];
        int                        errors;

        function new();
            clear_text();
            min_reg = cng_pkg::MIN_GRAM_RST;
            max_reg = cng_pkg::MAX_GRAM_RST;
            errors  = 0;
        endfunction

        function void clear_text();
            foreach (window[i])
            begin
                window[i] = '0;
            end
            seen = '0;
        endfunction

        function void write_reg(bit is_max, logic [cng_pkg::CFG_W-1:0] val);
            if (is_max)
            begin
                max_reg = val;
            end
            else
            begin
                min_reg = val;
            end
        endfunction

        // gram of len characters, window[top] is its first character
        function void push_gram(logic [cng_pkg::OFF_W-1:0] off, int len, int top,
                                bit is_end);
            gram_t                    g;
            logic [cng_pkg::CP_W-1:0] c [cng_pkg::NUM_CHARS];
            for (int j = 0; j < cng_pkg::NUM_CHARS; j++)
            begin
                c[j] = (!is_end && j < len) ? window[top - j] : '0;
            end
            g.start_offset = off;
            g.gram_length  = cng_pkg::LEN_W'(len);
            g.char_first   = c[0];
            g.char_second  = c[1];
            g.char_third   = c[2];
            g.char_fourth  = c[3];
            g.is_end       = is_end;
            g.last         = 1'b0;
            pending_grams.push_back(g);
        endfunction

        function void note_item(logic [cng_pkg::CP_W-1:0] cp, logic eot);
            int lo;
            int hi;
            int kmax;
            int first;
            bit grams;
            lo    = (min_reg == '0) ? 1 : int'(min_reg);
            hi    = (int'(max_reg) > cng_pkg::MAX_GRAM_DEF) ? cng_pkg::MAX_GRAM_DEF
                                                             : int'(max_reg);
            grams = lo <= hi;
            first = pending_grams.size();
            if (!eot)
            begin
                for (int i = cng_pkg::MAX_GRAM_DEF - 1; i > 0; i--)
                begin
                    window[i] = window[i - 1];
                end
                window[0] = cp;
                if (seen != '1)
                begin
                    seen++;
                end
                if (grams && seen >= cng_pkg::OFF_W'(hi))
                begin
                    for (int s = lo; s <= hi; s++)
                    begin
                        push_gram(seen - cng_pkg::OFF_W'(hi), s, hi - 1, 1'b0);
                    end
                end
            end
            else
            begin
                if (grams)
                begin
                    kmax = (seen >= cng_pkg::OFF_W'(hi - 1)) ? hi - 1 : int'(seen);
                    for (int k = kmax; k >= 1; k--)
                    begin
                        for (int s = lo; s <= k; s++)
                        begin
                            push_gram(seen - cng_pkg::OFF_W'(k), s, k - 1, 1'b0);
                        end
                    end
                end
                push_gram(seen, 0, 0, 1'b1);
                clear_text();
            end
            if (pending_grams.size() > first)
            begin
                pending_grams[pending_grams.size() - 1].last = 1'b1;
            end
        endfunction

        function void compare_field(string name, logic [cng_pkg::OFF_W-1:0] want,
                                    logic [cng_pkg::OFF_W-1:0] got);
            if (want !== got)
            begin
                $display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_gram(gram_t got);
            gram_t want;
            if (pending_grams.size() == 0)
            begin
                $display("%0t: result expected none, got offset 0x%0h length %0d end %0b",
                         $time, got.start_offset, got.gram_length, got.is_end);
                errors++;
                return;
            end
            want = pending_grams.pop_front();
            compare_field("start_offset", want.start_offset, got.start_offset);
            compare_field("gram_length", cng_pkg::OFF_W'(want.gram_length),
                          cng_pkg::OFF_W'(got.gram_length));
            compare_field("char_first", cng_pkg::OFF_W'(want.char_first),
                          cng_pkg::OFF_W'(got.char_first));
            compare_field("char_second", cng_pkg::OFF_W'(want.char_second),
                          cng_pkg::OFF_W'(got.char_second));
            compare_field("char_third", cng_pkg::OFF_W'(want.char_third),
                          cng_pkg::OFF_W'(got.char_third));
            compare_field("char_fourth", cng_pkg::OFF_W'(want.char_fourth),
                          cng_pkg::OFF_W'(got.char_fourth));
            compare_field("is_end", cng_pkg::OFF_W'(want.is_end),
                          cng_pkg::OFF_W'(got.is_end));
            compare_field("last", cng_pkg::OFF_W'(want.last), cng_pkg::OFF_W'(got.last));
        endfunction
    endclass

endpackage

>>> tb/character_ngram_emitter_core_tb.sv
`timescale 1ns / 1ps

module character_ngram_emitter_core_tb;

    // run limit in clock cycles, far above the slowest correct run
    localparam int CYCLE_LIMIT = 200000;
    // receiver hold-off long enough to fill the job queue and stall the input
    localparam int LONG_HOLD   = 100;
    // quiet cycles before a register write, covers latency and result-less steps
    localparam int QUIET_CYCLES = 8;
    localparam int SEGMENTS    = 6;
    localparam int SEG_ITEMS   = 28;

    logic                          clk = 1'b0;
    logic                          rst_n;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [cng_pkg::APB_AW-1:0]    paddr;
    logic [cng_pkg::APB_DW-1:0]    pwdata;
    logic [cng_pkg::APB_DW-1:0]    prdata;
    logic                          pready;

    cng_in_if  in_ch ();
    cng_out_if out_ch ();

    cng_gram_sb_pkg::gram_scoreboard sb = new();

    // idling percentages, set per phase by the stimulus
    int  src_idle = 0;
    int  snk_idle = 0;
    // asks the receiver for one long hold-off
    bit  hold_req = 1'b0;
    int  items_sent = 0;
    int  cycles = 0;

    // register settings for the random phases, the last one is drawn at random
    logic [cng_pkg::CFG_W-1:0] seg_min [SEGMENTS] = '{3'd1, 3'd4, 3'd1, 3'd2, 3'd0, 3'd1};
    logic [cng_pkg::CFG_W-1:0] seg_max [SEGMENTS] = '{3'd4, 3'd4, 3'd1, 3'd3, 3'd7, 3'd2};

    character_ngram_emitter_core u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // watchdog: a hung block or a lost result ends the run here
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // result side: ready changes at the falling edge, with the odd long hold-off
    initial
    begin
        int hold_n;
        out_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                hold_n   = 0;
                while (hold_n < LONG_HOLD)
                begin
                    out_ch.ready <= 1'b0;
                    hold_n++;
                    @(negedge clk);
                end
            end
            out_ch.ready <= ($urandom_range(99) >= snk_idle);
        end
    end

    // every result transfer is checked against the oldest predicted gram
    always @(posedge clk)
    begin
        cng_gram_sb_pkg::gram_t got;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got.start_offset = out_ch.start_offset;
            got.gram_length  = out_ch.gram_length;
            got.char_first   = out_ch.char_first;
            got.char_second  = out_ch.char_second;
            got.char_third   = out_ch.char_third;
            got.char_fourth  = out_ch.char_fourth;
            got.is_end       = out_ch.is_end;
            got.last         = out_ch.last;
            sb.check_gram(got);
        end
    end

    // one character or end mark, with random gaps before it; returns at a falling edge
    task automatic send_item(input logic [cng_pkg::CP_W-1:0] cp, input logic eot);
        while ($urandom_range(99) < src_idle)
        begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.code_point  <= cp;
        in_ch.end_of_text <= eot;
        do
            @(posedge clk);
        while (!in_ch.ready);
        sb.note_item(cp, eot);
        items_sent++;
        @(negedge clk);
    endtask

    // mix of full-width values, printable text, extremes and valid code points
    function automatic logic [cng_pkg::CP_W-1:0] rand_char();
        case ($urandom_range(3))
            0: return cng_pkg::CP_W'($urandom);
            1: return cng_pkg::CP_W'($urandom_range(126, 32));
            2:
            begin
                case ($urandom_range(3))
                    0: return '0;
                    1: return '1;
                    2: return 21'h10FFFF;
                    default: return 21'h110000;
                endcase
            end
            default: return cng_pkg::CP_W'($urandom_range(21'h10FFFF));
        endcase
    endfunction

    // a whole text: n characters then the end mark, whose code point is noise
    task automatic send_text(input int n);
        for (int i = 0; i < n; i++)
        begin
            send_item(rand_char(), 1'b0);
        end
        send_item(rand_char(), 1'b1);
    endtask

    // sender stops until every predicted result has been transferred
    task automatic wait_drain();
        in_ch.valid <= 1'b0;
        while (sb.pending_grams.size() != 0)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    // apb write then read-back of one register, entered and left at a falling edge
    task automatic apb_access(input logic [cng_pkg::APB_AW-3:0] idx,
                              input logic [cng_pkg::CFG_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= cng_pkg::APB_DW'(val);
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata !== cng_pkg::APB_DW'(val))
        begin
            $display("%0t: register %0d read expected 0x%0h, got 0x%0h",
                     $time, idx, cng_pkg::APB_DW'(val), prdata);
            sb.errors++;
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        sb.write_reg(idx == cng_pkg::REG_MAX_GRAM, val);
    endtask

    // registers only change with the block idle and the pipe empty
    task automatic set_grams(input logic [cng_pkg::CFG_W-1:0] lo,
                             input logic [cng_pkg::CFG_W-1:0] hi);
        wait_drain();
        repeat (QUIET_CYCLES) @(posedge clk);
        @(negedge clk);
        apb_access(cng_pkg::REG_MIN_GRAM, lo);
        apb_access(cng_pkg::REG_MAX_GRAM, hi);
    endtask

    initial
    begin
        int first_item;
        rst_n             = 1'b0;
        in_ch.valid       = 1'b0;
        in_ch.code_point  = '0;
        in_ch.end_of_text = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: reset setting, extreme and alternating code points
        send_item('0, 1'b0);
        send_item('1, 1'b0);
        send_item(21'h10FFFF, 1'b0);
        send_item(21'h155555, 1'b0);
        send_item(21'h0AAAAA, 1'b0);
        send_item(21'h0AAAAA, 1'b1);
        // end mark on an empty text
        send_item(21'h155555, 1'b1);

        // zero min_gram and an oversized max_gram, short text then a longer one
        set_grams(3'd0, 3'd7);
        send_item(21'h000041, 1'b0);
        send_item(21'h000042, 1'b0);
        send_item(21'h000043, 1'b0);
        send_item('0, 1'b1);
        for (int i = 0; i < 5; i++)
        begin
            send_item(cng_pkg::CP_W'(21'h0003B1 + i), 1'b0);
        end
        send_item('1, 1'b1);

        // min_gram above max_gram: end marks only
        set_grams(3'd4, 3'd3);
        send_item(21'h01F600, 1'b0);
        send_item(21'h000020, 1'b0);
        send_item('0, 1'b1);

        // text shorter than min_gram
        set_grams(3'd3, 3'd4);
        send_item(21'h000061, 1'b0);
        send_item(21'h000062, 1'b0);
        send_item('0, 1'b1);

        // random phases: receiver-heavy idling, then sender-heavy, then none
        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            if (seg == SEGMENTS - 1)
            begin
                set_grams(cng_pkg::CFG_W'($urandom_range(7)),
                          cng_pkg::CFG_W'($urandom_range(7)));
            end
            else
            begin
                set_grams(seg_min[seg], seg_max[seg]);
            end
            if (seg < 2)
            begin
                src_idle = 26;
                snk_idle = 62;
            end
            else if (seg < 4)
            begin
                src_idle = 62;
                snk_idle = 26;
            end
            else
            begin
                src_idle = 0;
                snk_idle = 0;
            end
            // long receiver hold-off while the sender keeps offering
            if (seg == 4)
            begin
                hold_req = 1'b1;
            end
            first_item = items_sent;
            while (items_sent - first_item < SEG_ITEMS)
            begin
                if ($urandom_range(7) == 0)
                begin
                    send_text($urandom_range(40, 9));
                end
                else
                begin
                    send_text($urandom_range(8));
                end
                // in the first half of phase 2 the sender pauses after each text until all results are in
                if (seg == 2 && items_sent - first_item < SEG_ITEMS / 2)
                begin
                    wait_drain();
                end
            end
        end

        wait_drain();
        repeat (QUIET_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.pending_grams.size() == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/cng_pkg.sv
rtl/cng_if.sv
rtl/cng_front.sv
rtl/cng_queue.sv
rtl/cng_back.sv
rtl/character_ngram_emitter_core.sv
tb/cng_gram_sb_pkg.sv
tb/character_ngram_emitter_core_tb.sv
